>>> sv/assert_macros.svh
// assertion macros for the sprite unpacker rtl
// clocked on clk_i, disabled while rst_ni is low; empty when SYNTHESIS is set
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SPPU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define SPPU_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define SPPU_ASSERT(lbl, prop, msg)
`define SPPU_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

>>> sv/sppu_pkg.sv
// types, codes and helpers for the sprite pixel unpacker
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package sppu_pkg;

  typedef enum logic [1:0] {
    MODE_PALETTE = 2'd0,
    MODE_IMAGE   = 2'd1,
    MODE_MASK    = 2'd2,
    MODE_UNUSED  = 2'd3
  } mode_e;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 13;

  localparam logic [CfgIdxW-1:0] CFG_PIXEL_BITS_LOG2  = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_FIRST_BIT_OFFSET = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_PIXELS_PER_LINE  = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_WORDS_PER_LINE   = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_PALETTE_ON       = 3'd4;

  localparam int unsigned WordW  = 32;
  localparam int unsigned LineW  = 13;
  localparam int unsigned ColW   = 24;
  localparam logic [2:0]  LgMax  = 3'd5;

  // low bits of a word that make one pixel
  function automatic logic [WordW-1:0] pix_mask(input logic [2:0] lg);
    logic [WordW-1:0] m;
    case (lg)
      3'd0:    m = 32'h0000_0001;
      3'd1:    m = 32'h0000_0003;
      3'd2:    m = 32'h0000_000F;
      3'd3:    m = 32'h0000_00FF;
      3'd4:    m = 32'h0000_FFFF;
      default: m = 32'hFFFF_FFFF;
    endcase
    return m;
  endfunction

  // drop one pixel from the bottom of the shift register
  function automatic logic [WordW-1:0] shr_pixel(input logic [WordW-1:0] w,
                                                 input logic [2:0] lg);
    logic [WordW-1:0] r;
    case (lg)
      3'd0:    r = {1'b0, w[31:1]};
      3'd1:    r = {2'b0, w[31:2]};
      3'd2:    r = {4'b0, w[31:4]};
      3'd3:    r = {8'b0, w[31:8]};
      3'd4:    r = {16'b0, w[31:16]};
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

>>> sv/sprite_pixel_unpack_palette.sv
// sprite line-word unpacker with colour palette, top level
// depends on sppu_pkg and assert_macros.svh
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+----------------------------------------
//  in      | sink      | in_valid_i/in_ready_o | mode_i, data_word_i, palette_index_i
//  out     | source    | out_valid_o/out_ready_i | pixel_x_o, red/green/blue/alpha_o, flags
//  cfg     | sink      | cfg_we_i             | cfg_idx_i, cfg_data_i
//
// a line word is loaded into the pixel shift register, then yields its pixels in
// turn; the input is not ready again until its last pixel is issued. the shift
// register moves one pixel a cycle while the output is not stalled; the palette
// read lands in the output register, so a pixel shows in the cycle after its issue.
// palette writes, mode 3 and words with no pixels leave the input ready.
// reset clears the counters and config to their defaults; the palette is not
// cleared and needs no sweep. a stalled output holds the issue stage in place.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module sprite_pixel_unpack_palette import sppu_pkg::*; #(
  parameter int unsigned MAX_LINE_PIXELS = 4096,
  parameter int unsigned PALETTE_DEPTH   = 256
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // configuration writes
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  // input transactions
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic [1:0]          mode_i,
  input  wire logic [31:0]         data_word_i,
  input  wire logic [7:0]          palette_index_i,
  // output transactions
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic [11:0]              pixel_x_o,
  output logic [7:0]               red_o,
  output logic [7:0]               green_o,
  output logic [7:0]               blue_o,
  output logic [7:0]               alpha_o,
  output logic                     is_mask_o,
  output logic                     last_of_word_o,
  output logic                     line_end_o
);

  localparam int unsigned IdxW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;

  // configuration registers
  logic [2:0]       pixel_bits_log2_q;
  logic [4:0]       first_bit_offset_q;
  logic [LineW-1:0] pixels_per_line_q;
  logic [LineW-1:0] words_per_line_q;
  logic             palette_on_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pixel_bits_log2_q  <= 3'd0;
      first_bit_offset_q <= 5'd0;
      pixels_per_line_q  <= 13'd1;
      words_per_line_q   <= 13'd1;
      palette_on_q       <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_PIXEL_BITS_LOG2:  pixel_bits_log2_q  <= cfg_data_i[2:0];
        CFG_FIRST_BIT_OFFSET: first_bit_offset_q <= cfg_data_i[4:0];
        CFG_PIXELS_PER_LINE:  pixels_per_line_q  <= cfg_data_i[LineW-1:0];
        CFG_WORDS_PER_LINE:   words_per_line_q   <= cfg_data_i[LineW-1:0];
        CFG_PALETTE_ON:       palette_on_q       <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // effective settings after clamping
  logic [2:0]       lg;
  logic [5:0]       size;
  logic [LineW-1:0] ppl;
  logic [LineW-1:0] wpl;

  always_comb begin
    lg   = (pixel_bits_log2_q > LgMax) ? LgMax : pixel_bits_log2_q;
    size = 6'd1 << lg;
    ppl  = ({19'd0, pixels_per_line_q} > 32'(MAX_LINE_PIXELS)) ?
           LineW'(MAX_LINE_PIXELS) : pixels_per_line_q;
    wpl  = (words_per_line_q == '0) ? 13'd1 : words_per_line_q;
  end

  // unpack engine state
  logic             busy_q;
  logic [WordW-1:0] shift_q;
  logic [5:0]       bits_left_q;
  logic             mask_pass_q;
  logic             wrap_q;
  logic [LineW-1:0] word_in_line_q;
  logic [LineW-1:0] pixel_in_line_q;

  // issue stage, one pixel held for the output
  logic             p1_valid_q;
  logic [11:0]      p1_x_q;
  logic [ColW-1:0]  p1_hi_q;
  logic             p1_bit0_q;
  logic             p1_in_range_q;
  logic             p1_mask_q;
  logic             p1_last_q;
  logic             p1_end_q;
  logic [ColW-1:0]  rd_q;

  logic             in_acc;
  logic             line_word;
  logic [4:0]       pos;
  logic [5:0]       bits_init;
  logic             can_emit;
  logic [LineW:0]   word_inc;
  logic             wrap_d;
  logic             issue;
  logic [WordW-1:0] val;
  logic [5:0]       bits_after;
  logic [LineW-1:0] pix_inc;
  logic             more;

  assign in_ready_o = !busy_q;
  assign in_acc     = in_valid_i && in_ready_o;
  assign line_word  = (mode_i == MODE_IMAGE) || (mode_i == MODE_MASK);
  assign issue      = busy_q && (!p1_valid_q || out_ready_i);

  always_comb begin
    // first word of a line skips the wasted low bits
    pos        = (word_in_line_q == '0) ? first_bit_offset_q : 5'd0;
    bits_init  = 6'd32 - {1'b0, pos};
    can_emit   = (size <= bits_init) && (pixel_in_line_q < ppl);
    word_inc   = {1'b0, word_in_line_q} + 14'd1;
    wrap_d     = word_inc >= {1'b0, wpl};
    val        = shift_q & pix_mask(lg);
    bits_after = bits_left_q - size;
    pix_inc    = pixel_in_line_q + 13'd1;
    more       = (size <= bits_after) && (pix_inc < ppl);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q          <= 1'b0;
      mask_pass_q     <= 1'b0;
      wrap_q          <= 1'b0;
      word_in_line_q  <= '0;
      pixel_in_line_q <= '0;
    end else if (in_acc && line_word) begin
      word_in_line_q <= wrap_d ? '0 : word_inc[LineW-1:0];
      wrap_q         <= wrap_d;
      mask_pass_q    <= (mode_i == MODE_MASK);
      if (can_emit) begin
        busy_q <= 1'b1;
      end else if (wrap_d) begin
        pixel_in_line_q <= '0;
      end
    end else if (issue) begin
      if (more) begin
        pixel_in_line_q <= pix_inc;
      end else begin
        busy_q          <= 1'b0;
        // the line closes only when its last word is spent
        pixel_in_line_q <= wrap_q ? '0 : pix_inc;
      end
    end
  end

  // shift register and bit budget, payload only
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      shift_q     <= data_word_i >> pos;
      bits_left_q <= bits_init;
    end else if (issue) begin
      shift_q     <= shr_pixel(shift_q, lg);
      bits_left_q <= bits_after;
    end
  end

  // palette memory, one write or one read a cycle
  logic [ColW-1:0] pal_mem [PALETTE_DEPTH];

  always_ff @(posedge clk_i) begin
    if (in_acc && (mode_i == MODE_PALETTE) &&
        ({24'd0, palette_index_i} < 32'(PALETTE_DEPTH))) begin
      pal_mem[palette_index_i[IdxW-1:0]] <= data_word_i[31:8];
    end
    if (issue) begin
      rd_q <= pal_mem[val[IdxW-1:0]];
    end
  end

  // issue stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_valid_q <= 1'b0;
    end else if (issue) begin
      p1_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      p1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      p1_x_q        <= pixel_in_line_q[11:0];
      p1_hi_q       <= val[31:8];
      p1_bit0_q     <= val[0];
      p1_in_range_q <= val < 32'(PALETTE_DEPTH);
      p1_mask_q     <= mask_pass_q;
      p1_last_q     <= !more;
      p1_end_q      <= pix_inc == ppl;
    end
  end

  // output formatting: palette colour is BBGGRR, direct value is BBGGRRxx
  logic [ColW-1:0] col;

  always_comb begin
    if (palette_on_q) begin
      col = p1_in_range_q ? rd_q : '0;
    end else begin
      col = p1_hi_q;
    end
    out_valid_o    = p1_valid_q;
    pixel_x_o      = p1_x_q;
    is_mask_o      = p1_mask_q;
    last_of_word_o = p1_last_q;
    line_end_o     = p1_end_q;
    red_o          = p1_mask_q ? 8'd0 : col[7:0];
    green_o        = p1_mask_q ? 8'd0 : col[15:8];
    blue_o         = p1_mask_q ? 8'd0 : col[23:16];
    alpha_o        = (p1_mask_q && p1_bit0_q) ? 8'd255 : 8'd0;
  end

  `SPPU_ASSERT(a_budget, busy_q |-> (size <= bits_left_q), "pixel issued past end of word")
  `SPPU_ASSERT(a_count, busy_q |-> (pixel_in_line_q < ppl), "pixel count past line length")
  `SPPU_ASSERT(a_end_last, (p1_valid_q && p1_end_q) |-> p1_last_q, "line end not last of word")
  `SPPU_ASSERT(a_done_last, $fell(busy_q) |-> (p1_valid_q && p1_last_q), "word closed without last pixel")

endmodule

`default_nettype wire

>>> sim/sprite_pixel_unpack_palette_tb.sv
// self-checking testbench for sprite_pixel_unpack_palette: palette load, directed line words,
// then random lines over several register settings with random stalls on both channels
// depends on sppu_pkg and the rtl of the block only
`timescale 1ns / 1ps

module sprite_pixel_unpack_palette_tb;
  import sppu_pkg::*;

  localparam int unsigned MaxLinePixels = 4096;
  localparam int unsigned PaletteDepth  = 256;
  // cycles allowed after the last expected pixel for words that give none
  localparam int unsigned SettleCycles  = 40;
  // long receiver hold-off so that the block backs up into its input
  localparam int unsigned HoldOffCycles = 400;
  localparam int unsigned RunLimitNs    = 20_000_000;
  // register index with nothing behind it
  localparam logic [CfgIdxW-1:0] CFG_UNMAPPED = 3'd7;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;
  logic                in_valid_i;
  logic                in_ready_o;
  logic [1:0]          mode_i;
  logic [31:0]         data_word_i;
  logic [7:0]          palette_index_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic [11:0]         pixel_x_o;
  logic [7:0]          red_o;
  logic [7:0]          green_o;
  logic [7:0]          blue_o;
  logic [7:0]          alpha_o;
  logic                is_mask_o;
  logic                last_of_word_o;
  logic                line_end_o;

  typedef struct packed {
    logic [11:0] pixel_x;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic        is_mask;
    logic        last_of_word;
    logic        line_end;
  } pixel_t;

  // mirror of the unpacker: registers, palette, line counters and the pixels still owed
  class pixel_scoreboard;
    bit [2:0]    pix_lg;
    bit [4:0]    first_offset;
    bit [12:0]   line_pixels = 13'd1;
    bit [12:0]   line_words  = 13'd1;
    bit          palette_en;
    bit [23:0]   colours [PaletteDepth];
    bit          loaded [PaletteDepth];
    int unsigned word_count;
    int unsigned pixel_count;
    pixel_t      expected_pixels [$];
    int unsigned errors;
    int unsigned image_pixels;
    int unsigned mask_pixels;
    int unsigned line_ends;
    int unsigned palette_writes;
    int unsigned words_seen;

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] value);
      case (idx)
        CFG_PIXEL_BITS_LOG2:  pix_lg       = value[2:0];
        CFG_FIRST_BIT_OFFSET: first_offset = value[4:0];
        CFG_PIXELS_PER_LINE:  line_pixels  = value[12:0];
        CFG_WORDS_PER_LINE:   line_words   = value[12:0];
        CFG_PALETTE_ON:       palette_en   = value[0];
        default: ;
      endcase
    endfunction

    // image pixels that would look up a palette entry never loaded are moved onto
    // one of the low entries, which are loaded first
    function logic [31:0] legal_word(mode_e mode, logic [31:0] word);
      int unsigned size;
      int unsigned pos;
      int unsigned ppl;
      int unsigned cnt;
      logic [31:0] field;
      logic [31:0] val;
      if (mode != MODE_IMAGE || !palette_en) return word;
      size = 1 << ((pix_lg > LgMax) ? LgMax : pix_lg);
      pos  = (word_count == 0) ? first_offset : 0;
      ppl  = (line_pixels > MaxLinePixels) ? MaxLinePixels : line_pixels;
      cnt  = pixel_count;
      while (pos + size <= 32 && cnt < ppl) begin
        field = (size == 32) ? 32'hFFFF_FFFF : ((32'd1 << size) - 32'd1);
        val   = (word >> pos) & field;
        if (val < PaletteDepth && !loaded[val[7:0]])
          word = (word & ~(field << pos)) | ((val & 32'd7) << pos);
        cnt++;
        pos += size;
      end
      return word;
    endfunction

    // expected pixels of one line word, appended in output order
    function void unpack_word(bit mask_pass, logic [31:0] word);
      int unsigned size;
      int unsigned pos;
      int unsigned ppl;
      int unsigned wpl;
      logic [31:0] val;
      logic [31:0] col;
      pixel_t      p;
      size = 1 << ((pix_lg > LgMax) ? LgMax : pix_lg);
      pos  = (word_count == 0) ? first_offset : 0;
      ppl  = (line_pixels > MaxLinePixels) ? MaxLinePixels : line_pixels;
      wpl  = (line_words == 0) ? 1 : line_words;
      words_seen++;
      while (pos + size <= 32 && pixel_count < ppl) begin
        val = (size == 32) ? word : (word >> pos) & ((32'd1 << size) - 32'd1);
        p = '0;
        p.pixel_x = pixel_count[11:0];
        if (mask_pass) begin
          p.alpha   = val[0] ? 8'hFF : 8'h00;
          p.is_mask = 1'b1;
          mask_pixels++;
        end else begin
          if (!palette_en) col = val;
          else if (val < PaletteDepth) col = {colours[val[7:0]], 8'h00};
          else col = '0;
          p.red   = col[15:8];
          p.green = col[23:16];
          p.blue  = col[31:24];
          image_pixels++;
        end
        pixel_count++;
        pos += size;
        p.line_end     = (pixel_count == ppl);
        p.last_of_word = !(pos + size <= 32 && pixel_count < ppl);
        if (p.line_end) line_ends++;
        expected_pixels.push_back(p);
      end
      word_count++;
      if (word_count >= wpl) begin
        word_count  = 0;
        pixel_count = 0;
      end
    endfunction

    function void accept_item(mode_e mode, logic [31:0] word, logic [7:0] index);
      case (mode)
        MODE_PALETTE: begin
          colours[index] = word[31:8];
          loaded[index]  = 1'b1;
          palette_writes++;
        end
        MODE_IMAGE: unpack_word(1'b0, word);
        MODE_MASK:  unpack_word(1'b1, word);
        default: ;
      endcase
    endfunction

    function bit field_differs(string name, int unsigned want, int unsigned got);
      if (want == got) return 1'b0;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      return 1'b1;
    endfunction

    function void check_pixel(pixel_t got);
      pixel_t want;
      bit     bad;
      if (expected_pixels.size() == 0) begin
        $display("%0t: pixel at x %0d with none expected", $time, got.pixel_x);
        errors++;
        return;
      end
      want = expected_pixels.pop_front();
      bad  = 1'b0;
      bad |= field_differs("pixel_x", want.pixel_x, got.pixel_x);
      bad |= field_differs("red", want.red, got.red);
      bad |= field_differs("green", want.green, got.green);
      bad |= field_differs("blue", want.blue, got.blue);
      bad |= field_differs("alpha", want.alpha, got.alpha);
      bad |= field_differs("is_mask", want.is_mask, got.is_mask);
      bad |= field_differs("last_of_word", want.last_of_word, got.last_of_word);
      bad |= field_differs("line_end", want.line_end, got.line_end);
      if (bad) errors++;
    endfunction

    function bit busy();
      return expected_pixels.size() != 0;
    endfunction
  endclass

  pixel_scoreboard sb = new;

  // stall percentages, changed by the stimulus between phases
  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;
  // set by the stimulus, cleared by the receiver when it starts a hold-off
  bit          hold_request;
  int unsigned hold_offs;
  int unsigned settings;

  sprite_pixel_unpack_palette uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .mode_i          (mode_i),
    .data_word_i     (data_word_i),
    .palette_index_i (palette_index_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .pixel_x_o       (pixel_x_o),
    .red_o           (red_o),
    .green_o         (green_o),
    .blue_o          (blue_o),
    .alpha_o         (alpha_o),
    .is_mask_o       (is_mask_o),
    .last_of_word_o  (last_of_word_o),
    .line_end_o      (line_end_o)
  );

  // 20 ns period
  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // every accepted output transaction is checked against the oldest owed pixel
  always @(posedge clk_i) begin
    pixel_t got;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got.pixel_x      = pixel_x_o;
      got.red          = red_o;
      got.green        = green_o;
      got.blue         = blue_o;
      got.alpha        = alpha_o;
      got.is_mask      = is_mask_o;
      got.last_of_word = last_of_word_o;
      got.line_end     = line_end_o;
      sb.check_pixel(got);
    end
  end

  // receiver: random back-pressure, plus one long hold-off counted here in cycles
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready_i <= 1'b0;
        repeat (HoldOffCycles) @(negedge clk_i);
        hold_offs++;
      end
      out_ready_i <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // watchdog
  initial begin
    #(RunLimitNs * 1ns);
    $display("sprite_pixel_unpack_palette_tb: done, errors");
    $finish;
  end

  function automatic logic [31:0] rand_word();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // one input transaction: optional idle cycles, then hold valid until accepted
  task automatic send_item(input mode_e mode, input logic [31:0] word, input logic [7:0] index);
    logic [31:0] w;
    w = sb.legal_word(mode, word);
    @(negedge clk_i);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i      <= 1'b1;
    mode_i          <= mode;
    data_word_i     <= w;
    palette_index_i <= index;
    do @(posedge clk_i); while (!in_ready_o);
    sb.accept_item(mode, w, index);
  endtask

  // stop offering, let every owed pixel out, then allow for words still in flight
  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.busy()) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // leaves the write enable high; the caller lowers it after its last write
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] value);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    sb.set_reg(idx, value);
  endtask

  task automatic configure(input int unsigned lg, input int unsigned offset,
                           input int unsigned ppl, input int unsigned wpl, input bit pal);
    wait_idle();
    write_reg(CFG_PIXEL_BITS_LOG2, CfgDataW'(lg));
    write_reg(CFG_FIRST_BIT_OFFSET, CfgDataW'(offset));
    write_reg(CFG_PIXELS_PER_LINE, CfgDataW'(ppl));
    write_reg(CFG_WORDS_PER_LINE, CfgDataW'(wpl));
    write_reg(CFG_PALETTE_ON, CfgDataW'(pal));
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    settings++;
  endtask

  // random lines of the current setting, with palette writes and unused-mode noise mixed in
  task automatic random_lines(input int unsigned n_words, input bit hold);
    int unsigned done_words;
    int unsigned in_line;
    int unsigned wpl;
    int unsigned pick;
    mode_e       line_mode;
    done_words = 0;
    in_line    = 0;
    wpl        = (sb.line_words == 0) ? 1 : sb.line_words;
    line_mode  = MODE_IMAGE;
    if (hold) hold_request = 1'b1;
    while (done_words < n_words) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        send_item(MODE_PALETTE, $urandom, 8'($urandom));
      end else if (pick < 11) begin
        send_item(MODE_UNUSED, rand_word(), 8'($urandom));
      end else begin
        // pass usually fixed per line, now and then switched mid-line
        if (in_line == 0 || $urandom_range(9) == 0)
          line_mode = ($urandom_range(2) == 0) ? MODE_MASK : MODE_IMAGE;
        send_item(line_mode, rand_word(), 8'($urandom));
        in_line = (in_line + 1) % wpl;
        done_words++;
      end
    end
  endtask

  initial begin
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = CFG_PIXEL_BITS_LOG2;
    cfg_data_i      = '0;
    in_valid_i      = 1'b0;
    mode_i          = MODE_PALETTE;
    data_word_i     = '0;
    palette_index_i = '0;
    tx_idle_pct     = 37;
    rx_idle_pct     = 87;
    hold_request    = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // load the low entries and the top one; image words are steered onto loaded entries
    for (int i = 0; i < 8; i++)
      send_item(MODE_PALETTE, (i == 0) ? 32'h0 : $urandom, 8'(i));
    send_item(MODE_PALETTE, 32'hFFFF_FFFF, 8'(PaletteDepth - 1));

    // directed: one-bit pixels, a whole line per word, both passes
    configure(0, 0, 32, 1, 1'b0);
    send_item(MODE_IMAGE, 32'h0000_0000, 8'h00);
    send_item(MODE_IMAGE, 32'hFFFF_FFFF, 8'hFF);
    send_item(MODE_MASK, 32'hAAAA_AAAA, 8'h00);
    send_item(MODE_MASK, 32'hFFFF_FFFF, 8'h00);
    send_item(MODE_UNUSED, 32'hFFFF_FFFF, 8'hFF);
    wait_idle();
    write_reg(CFG_UNMAPPED, '1);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;

    // 32-bit pixels through the palette: out-of-range value, top and bottom entries
    configure(5, 0, 2, 2, 1'b1);
    send_item(MODE_IMAGE, 32'hFFFF_FFFF, 8'h00);
    send_item(MODE_IMAGE, 32'h0000_00FF, 8'h00);
    send_item(MODE_IMAGE, 32'h0000_0000, 8'h00);
    send_item(MODE_MASK, 32'hFFFF_FFFE, 8'h00);

    // first offset not a multiple of the pixel size, line ends on the last pixel of its second word
    configure(3, 5, 7, 2, 1'b1);
    send_item(MODE_IMAGE, 32'h1234_5678, 8'h00);
    send_item(MODE_IMAGE, 32'h9ABC_DEF0, 8'h00);

    // no pixels per line, zero words per line, oversized pixel select
    configure(6, 31, 0, 0, 1'b0);
    send_item(MODE_IMAGE, 32'hDEAD_BEEF, 8'h00);
    send_item(MODE_MASK, 32'hFFFF_FFFF, 8'h00);

    // pixel count beyond the maximum, too few words to finish the line
    configure(2, 0, 8191, 3, 1'b0);
    send_item(MODE_IMAGE, 32'h0123_4567, 8'h00);
    send_item(MODE_MASK, 32'h89AB_CDEF, 8'h00);
    send_item(MODE_IMAGE, 32'hFFFF_0000, 8'h00);

    // random lines; the first setting also carries the long receiver hold-off
    configure(0, 0, 40, 2, 1'b0);
    random_lines(10, 1'b1);
    configure(1, 6, 20, 3, 1'b1);
    random_lines(9, 1'b0);
    configure(2, 4, 13, 2, 1'b1);
    random_lines(9, 1'b0);

    tx_idle_pct = 87;
    rx_idle_pct = 37;
    configure(3, 3, 9, 3, 1'b1);
    random_lines(9, 1'b0);
    configure(4, 16, 5, 4, 1'b1);
    random_lines(9, 1'b0);
    configure(5, 31, 3, 5, 1'b1);
    random_lines(9, 1'b0);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    configure(7, 0, 8191, 0, 1'b0);
    random_lines(9, 1'b0);
    configure(0, 31, 4096, 4096, 1'b1);
    random_lines(9, 1'b0);

    wait_idle();
    $display("covered %0d line words, %0d image and %0d mask pixels, %0d line ends",
             sb.words_seen, sb.image_pixels, sb.mask_pixels, sb.line_ends);
    $display("%0d palette writes over %0d register settings, %0d long receiver hold-offs",
             sb.palette_writes, settings, hold_offs);
    if (sb.errors == 0 && !sb.busy()) begin
      $display("sprite_pixel_unpack_palette_tb: done, clean");
    end else begin
      $display("sprite_pixel_unpack_palette_tb: done, errors");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+sv
sv/sppu_pkg.sv
sv/sprite_pixel_unpack_palette.sv
sim/sprite_pixel_unpack_palette_tb.sv
